@@ rtl/complex_to_polar_core_defines.svh @@
// Assertion macros used by the checker file of the complex-to-polar core.
`ifndef COMPLEX_TO_POLAR_CORE_DEFINES_SVH
`define COMPLEX_TO_POLAR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that stays active during reset.
`define CTP_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ctp_pkg.sv @@
`default_nettype none

package ctp_pkg;

    // Sample and result widths.
    localparam int SAMPLE_WIDTH = 16;
    localparam int ANGLE_STEPS  = 16;
    localparam int MAG_W        = 16;
    localparam int PHASE_W      = 16;

    // Internal widths: exact sum of squares, CORDIC vector with growth headroom,
    // and the 32-bit angle accumulator where 2^31 stands for pi.
    localparam int SUM_W = 2 * SAMPLE_WIDTH;
    localparam int XY_W  = SAMPLE_WIDTH + 3;
    localparam int Z_W   = 32;

    localparam logic [Z_W-1:0] Z_PI   = Z_W'(1) << (Z_W - 1);
    localparam logic [Z_W-1:0] Z_HALF = Z_W'(1) << (Z_W - PHASE_W - 1);

    // Pipeline depths of the two datapaths; the shorter one is padded to match.
    localparam int SQRT_DEPTH   = 2 + SAMPLE_WIDTH;
    localparam int CORDIC_DEPTH = 2 + ANGLE_STEPS;
    localparam int CORE_DEPTH   = (SQRT_DEPTH > CORDIC_DEPTH) ? SQRT_DEPTH : CORDIC_DEPTH;

    // Arctangent of 2^-i in units where 2^31 stands for pi.
    localparam int ATAN_ENTRIES = 32;
    localparam logic [Z_W-1:0] ATAN_UNITS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Result of each datapath as it leaves its pipeline.
    typedef struct packed {
        logic                    valid;
        logic [SAMPLE_WIDTH-1:0] value;
    } t_mag_res;

    typedef struct packed {
        logic               valid;
        logic [PHASE_W-1:0] value;
    } t_phase_res;

endpackage

`default_nettype wire

@@ rtl/ctp_sqrt.sv @@
`default_nettype none

module ctp_sqrt (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic signed [ctp_pkg::SAMPLE_WIDTH-1:0] i_re,
    input  logic signed [ctp_pkg::SAMPLE_WIDTH-1:0] i_im,
    output ctp_pkg::t_mag_res                       o_res
);
    import ctp_pkg::*;

    localparam int Steps = SAMPLE_WIDTH;
    localparam int Pad   = CORE_DEPTH - SQRT_DEPTH;

    logic signed [SUM_W-1:0] n_sq_re;
    logic signed [SUM_W-1:0] n_sq_im;
    logic [SUM_W-1:0]        r_sq_re;
    logic [SUM_W-1:0]        r_sq_im;
    logic                    r_sq_valid;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_sum_valid;
    logic [SUM_W-1:0]        r_rem      [Steps];
    logic [SUM_W-1:0]        r_root     [Steps];
    logic                    r_it_valid [Steps];
    t_mag_res                w_round;

    // Squares are taken on the signed samples; the products are never negative.
    assign n_sq_re = SUM_W'(i_re) * SUM_W'(i_re);
    assign n_sq_im = SUM_W'(i_im) * SUM_W'(i_im);

    // Control bits of the square and sum stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid  <= 1'b0;
            r_sum_valid <= 1'b0;
        end else begin
            r_sq_valid  <= i_valid;
            r_sum_valid <= r_sq_valid;
        end
    end

    // Square and sum payload registers.
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_sq_re <= n_sq_re;
            r_sq_im <= n_sq_im;
        end
        if (r_sq_valid) begin
            r_sum <= r_sq_re + r_sq_im;
        end
    end

    // One root bit per stage: restoring square root over bit pairs.
    for (genvar j = 0; j < Steps; j++) begin : g_step
        localparam logic [SUM_W-1:0] Bit = SUM_W'(1) << (SUM_W - 2 - 2 * j);

        logic [SUM_W-1:0] w_rem;
        logic [SUM_W-1:0] w_root;
        logic             w_valid;
        logic [SUM_W-1:0] w_try;
        logic             w_take;
        logic [SUM_W-1:0] n_rem;
        logic [SUM_W-1:0] n_root;

        if (j == 0) begin : g_first
            assign w_rem   = r_sum;
            assign w_root  = '0;
            assign w_valid = r_sum_valid;
        end else begin : g_next
            assign w_rem   = r_rem[j-1];
            assign w_root  = r_root[j-1];
            assign w_valid = r_it_valid[j-1];
        end

        assign w_try  = w_root + Bit;
        assign w_take = (w_rem >= w_try);
        assign n_rem  = w_take ? (w_rem - w_try) : w_rem;
        assign n_root = w_take ? ((w_root >> 1) + Bit) : (w_root >> 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_it_valid[j] <= 1'b0;
            end else begin
                r_it_valid[j] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_valid) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
            end
        end
    end

    // Round to nearest: step up when the remainder exceeds the root.
    always_comb begin
        w_round.valid = r_it_valid[Steps-1];
        w_round.value = r_root[Steps-1][SAMPLE_WIDTH-1:0]
                      + SAMPLE_WIDTH'(r_rem[Steps-1] > r_root[Steps-1]);
    end

    // Delay line that lines this path up with the phase path.
    if (Pad == 0) begin : g_no_pad
        assign o_res = w_round;
    end else begin : g_pad
        logic                    r_pad_valid [Pad];
        logic [SAMPLE_WIDTH-1:0] r_pad_value [Pad];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int k = 0; k < Pad; k++) begin
                    r_pad_valid[k] <= 1'b0;
                end
            end else begin
                r_pad_valid[0] <= w_round.valid;
                for (int k = 1; k < Pad; k++) begin
                    r_pad_valid[k] <= r_pad_valid[k-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_pad_value[0] <= w_round.value;
            for (int k = 1; k < Pad; k++) begin
                r_pad_value[k] <= r_pad_value[k-1];
            end
        end

        assign o_res = '{valid: r_pad_valid[Pad-1], value: r_pad_value[Pad-1]};
    end

endmodule

`default_nettype wire

@@ rtl/ctp_cordic.sv @@
`default_nettype none

module ctp_cordic (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic signed [ctp_pkg::SAMPLE_WIDTH-1:0] i_re,
    input  logic signed [ctp_pkg::SAMPLE_WIDTH-1:0] i_im,
    output ctp_pkg::t_phase_res                     o_res
);
    import ctp_pkg::*;

    localparam int Steps = ANGLE_STEPS;
    localparam int Pad   = CORE_DEPTH - CORDIC_DEPTH;

    logic signed [XY_W-1:0] w_re_ext;
    logic signed [XY_W-1:0] w_im_ext;
    logic                   w_neg;
    logic signed [XY_W-1:0] n_x0;
    logic signed [XY_W-1:0] n_y0;
    logic [Z_W-1:0]         n_z0;
    logic                   n_zero0;
    logic signed [XY_W-1:0] r_x0;
    logic signed [XY_W-1:0] r_y0;
    logic [Z_W-1:0]         r_z0;
    logic                   r_zero0;
    logic                   r_pre_valid;
    logic signed [XY_W-1:0] r_x        [Steps-1];
    logic signed [XY_W-1:0] r_y        [Steps-1];
    logic [Z_W-1:0]         r_z        [Steps];
    logic                   r_zero     [Steps];
    logic                   r_it_valid [Steps];
    logic [Z_W-1:0]         w_z_round;
    logic [PHASE_W-1:0]     n_phase;
    logic [PHASE_W-1:0]     r_phase;
    logic                   r_phase_valid;
    t_phase_res             w_final;

    // Fold the left half-plane into the right one and start the angle at pi.
    assign w_re_ext = XY_W'(i_re);
    assign w_im_ext = XY_W'(i_im);
    assign w_neg    = i_re[SAMPLE_WIDTH-1];
    assign n_x0     = w_neg ? -w_re_ext : w_re_ext;
    assign n_y0     = w_neg ? -w_im_ext : w_im_ext;
    assign n_z0     = w_neg ? Z_PI : '0;
    assign n_zero0  = (i_re == '0) && (i_im == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else begin
            r_pre_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_x0    <= n_x0;
            r_y0    <= n_y0;
            r_z0    <= n_z0;
            r_zero0 <= n_zero0;
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar j = 0; j < Steps; j++) begin : g_step
        logic signed [XY_W-1:0] w_y;
        logic [Z_W-1:0]         w_z;
        logic                   w_zero;
        logic                   w_valid;
        logic [Z_W-1:0]         n_z;

        if (j == 0) begin : g_first
            assign w_y     = r_y0;
            assign w_z     = r_z0;
            assign w_zero  = r_zero0;
            assign w_valid = r_pre_valid;
        end else begin : g_next
            assign w_y     = r_y[j-1];
            assign w_z     = r_z[j-1];
            assign w_zero  = r_zero[j-1];
            assign w_valid = r_it_valid[j-1];
        end

        assign n_z = w_y[XY_W-1] ? (w_z - ATAN_UNITS[j]) : (w_z + ATAN_UNITS[j]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_it_valid[j] <= 1'b0;
            end else begin
                r_it_valid[j] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_valid) begin
                r_z[j]    <= n_z;
                r_zero[j] <= w_zero;
            end
        end

        // The vector itself is needed only by the stages that follow.
        if (j < Steps - 1) begin : g_rotate
            logic signed [XY_W-1:0] w_x;
            logic signed [XY_W-1:0] w_dx;
            logic signed [XY_W-1:0] w_dy;
            logic signed [XY_W-1:0] n_x;
            logic signed [XY_W-1:0] n_y;

            if (j == 0) begin : g_first_x
                assign w_x = r_x0;
            end else begin : g_next_x
                assign w_x = r_x[j-1];
            end

            // Arithmetic shifts round toward minus infinity.
            assign w_dx = w_y >>> j;
            assign w_dy = w_x >>> j;
            assign n_x  = w_y[XY_W-1] ? (w_x - w_dx) : (w_x + w_dx);
            assign n_y  = w_y[XY_W-1] ? (w_y + w_dy) : (w_y - w_dy);

            always_ff @(posedge i_clk) begin
                if (w_valid) begin
                    r_x[j] <= n_x;
                    r_y[j] <= n_y;
                end
            end
        end
    end

    // Round the accumulated angle half up to the phase width; zero input gives zero.
    assign w_z_round = r_z[Steps-1] + Z_HALF;
    assign n_phase   = r_zero[Steps-1] ? '0 : w_z_round[Z_W-1 -: PHASE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_valid <= 1'b0;
        end else begin
            r_phase_valid <= r_it_valid[Steps-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_it_valid[Steps-1]) begin
            r_phase <= n_phase;
        end
    end

    assign w_final = '{valid: r_phase_valid, value: r_phase};

    // Delay line that lines this path up with the magnitude path.
    if (Pad == 0) begin : g_no_pad
        assign o_res = w_final;
    end else begin : g_pad
        logic               r_pad_valid [Pad];
        logic [PHASE_W-1:0] r_pad_value [Pad];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int k = 0; k < Pad; k++) begin
                    r_pad_valid[k] <= 1'b0;
                end
            end else begin
                r_pad_valid[0] <= w_final.valid;
                for (int k = 1; k < Pad; k++) begin
                    r_pad_valid[k] <= r_pad_valid[k-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_pad_value[0] <= w_final.value;
            for (int k = 1; k < Pad; k++) begin
                r_pad_value[k] <= r_pad_value[k-1];
            end
        end

        assign o_res = '{valid: r_pad_valid[Pad-1], value: r_pad_value[Pad-1]};
    end

endmodule

`default_nettype wire

@@ rtl/complex_to_polar_core.sv @@
// The core has CORE_DEPTH + 1 register stages (19 here): the square-root and CORDIC
// pipelines, which run side by side, then the output register that drives o_valid.
// Throughput: one item per cycle; busy stays low because the result side never stalls.
// Reset (synchronous, active low) clears all valid bits and drops items in flight;
// o_valid is low from the first edge with reset asserted.
`default_nettype none

module complex_to_polar_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [ctp_pkg::SAMPLE_WIDTH-1:0] i_real_part,
    input  logic signed [ctp_pkg::SAMPLE_WIDTH-1:0] i_imag_part,
    output logic                                    o_valid,
    output logic [ctp_pkg::MAG_W-1:0]               o_magnitude,
    output logic signed [ctp_pkg::PHASE_W-1:0]      o_phase
);
    import ctp_pkg::*;

    logic       w_accept;
    t_mag_res   w_mag;
    t_phase_res w_phase;
    logic       r_valid;
    logic [MAG_W-1:0]   r_magnitude;
    logic [PHASE_W-1:0] r_phase;

    // The pipeline moves every cycle, so a transfer is taken whenever start is high.
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    ctp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_re    (i_real_part),
        .i_im    (i_imag_part),
        .o_res   (w_mag)
    );

    ctp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_re    (i_real_part),
        .i_im    (i_imag_part),
        .o_res   (w_phase)
    );

    // Output register: both paths carry the same item in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_mag.valid & w_phase.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mag.valid) begin
            r_magnitude <= MAG_W'(w_mag.value);
            r_phase     <= w_phase.value;
        end
    end

    assign o_valid     = r_valid;
    assign o_magnitude = r_magnitude;
    assign o_phase     = $signed(r_phase);

endmodule

`default_nettype wire

@@ rtl/ctp_checker.sv @@
`default_nettype none
`include "complex_to_polar_core_defines.svh"

module ctp_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    input  logic                                    busy,
    input  logic signed [ctp_pkg::SAMPLE_WIDTH-1:0] i_real_part,
    input  logic signed [ctp_pkg::SAMPLE_WIDTH-1:0] i_imag_part,
    input  logic                                    o_valid,
    input  logic [ctp_pkg::MAG_W-1:0]               o_magnitude,
    input  logic signed [ctp_pkg::PHASE_W-1:0]      o_phase
);
    import ctp_pkg::*;

    // The core pipeline plus the output register.
    localparam int Latency = CORE_DEPTH + 1;

    logic w_take;
    logic w_zero;
    logic w_nil;

    // Accepted transfers, zero samples among them, and an all-zero result.
    assign w_take = start && !busy;
    assign w_zero = w_take && (i_real_part == '0) && (i_imag_part == '0);
    assign w_nil  = (o_magnitude == '0) && (o_phase == '0);

    // The core never refuses a transfer.
    `CTP_ASSERT_IMPLY(a_never_busy, i_clk, i_rst_n, 1'b1, !busy, "busy went high")

    // Every result comes from an accepted transfer, delayed through the core pipeline and output register.
    `CTP_ASSERT_IMPLY(a_has_source, i_clk, i_rst_n, o_valid, $past(w_take, Latency), "stray result")

    // A zero sample yields zero magnitude and zero phase.
    `CTP_ASSERT_IMPLY(a_zero, i_clk, i_rst_n, o_valid && $past(w_zero, Latency), w_nil, "nonzero polar")

    // Reset flushes the pipeline at the next edge.
    `CTP_ASSERT_NEXT(a_reset_flushes, i_clk, !i_rst_n, !o_valid, "result strobe after reset")

endmodule

bind complex_to_polar_core ctp_checker u_ctp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_real_part (i_real_part),
    .i_imag_part (i_imag_part),
    .o_valid     (o_valid),
    .o_magnitude (o_magnitude),
    .o_phase     (o_phase)
);

`default_nettype wire
